@@ rtl/core/ptp_pkg.sv @@
// Package for the priority task picker: sizes, command and status codes,
// and the types shared by the cells and the top level. No dependencies.
`default_nettype none

package ptp_pkg;

    // Task table size and field widths.
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int PRIO_W    = 8;
    localparam int TICK_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;

    // Priority value that is never picked.
    localparam logic [PRIO_W-1:0] PRIO_NEVER = 8'hFF;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BLOCK  = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

    // Scan token that walks the chain of cells during a pick.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [PRIO_W-1:0] best_prio;
        logic [IDX_W-1:0]  best_id;
        logic [IDX_W-1:0]  pos;
    } t_token;

    // Write request from the top level to one cell.
    typedef struct packed {
        logic              create;
        logic              block;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] wake;
    } t_cell_wr;

endpackage

`default_nettype wire

@@ rtl/core/ptp_if.sv @@
// Handshake interfaces for the command and response channels.
// Depends on ptp_pkg for field widths.
`default_nettype none

interface ptp_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ptp_pkg::CMD_W-1:0]    cmd;
    logic [ptp_pkg::PRIO_W-1:0]   priority_req;
    logic [ptp_pkg::IDX_W-1:0]    task_index;
    logic [ptp_pkg::TICK_W-1:0]   wake_at;

    modport source (output valid, cmd, priority_req, task_index, wake_at, input ready);
    modport sink   (input valid, cmd, priority_req, task_index, wake_at, output ready);
endinterface

interface ptp_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ptp_pkg::STAT_W-1:0]   status;
    logic [ptp_pkg::IDX_W-1:0]    task_id;

    modport source (output valid, status, task_id, input ready);
    modport sink   (input valid, status, task_id, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ptp_cell.sv @@
// One task slot of the scheduler chain: holds priority, blocked flag and
// wake tick, and updates the passing scan token. Depends on ptp_pkg.
`default_nettype none

module ptp_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire ptp_pkg::t_cell_wr       i_wr,
    input  wire [ptp_pkg::TICK_W-1:0]    i_tick,
    input  wire ptp_pkg::t_token         i_tok,
    output ptp_pkg::t_token              o_tok
);

    logic                         r_used;
    logic                         r_blocked;
    logic [ptp_pkg::TICK_W-1:0]   r_wake;
    logic [ptp_pkg::PRIO_W-1:0]   r_prio;
    ptp_pkg::t_token              r_tok;
    ptp_pkg::t_token              n_tok;

    logic w_woken;
    logic w_ready;

    // A blocked task wakes once the counter reaches its wake tick.
    assign w_woken = r_blocked && (i_tick >= r_wake);
    assign w_ready = r_used && (!r_blocked || w_woken);

    // Compare this slot against the best candidate so far.
    always_comb begin
        n_tok     = i_tok;
        n_tok.pos = i_tok.pos + 1'b1;
        if (w_ready && (r_prio < i_tok.best_prio)) begin
            n_tok.found     = 1'b1;
            n_tok.best_prio = r_prio;
            n_tok.best_id   = i_tok.pos;
        end
    end

    // Slot state: create and block writes, and wakeup during a scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_blocked <= 1'b0;
            r_wake    <= '0;
        end else if (i_wr.create) begin
            r_used    <= 1'b1;
            r_blocked <= 1'b0;
            r_wake    <= '0;
        end else if (i_wr.block) begin
            r_blocked <= 1'b1;
            r_wake    <= i_wr.wake;
        end else if (i_tok.valid && r_used && w_woken) begin
            r_blocked <= 1'b0;
        end
    end

    // Priority is only read once the slot is in use.
    always_ff @(posedge i_clk) begin
        if (i_wr.create) begin
            r_prio <= i_wr.prio;
        end
    end

    // Token register toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

@@ rtl/core/priority_task_picker_with_wakeup.sv @@
// Fixed-priority task picker with blocking and tick-based wakeup.
// Depends on ptp_pkg, ptp_if (ptp_cmd_if, ptp_rsp_if) and ptp_cell.
//
// The block keeps a table of up to 16 tasks in a chain of identical cells,
// one task per cell, plus a task count and a 32-bit tick counter. Create,
// tick and block items are handled without a scan: the response is valid the
// cycle after the item is accepted. A pick item sends a scan token down the
// chain, one cell per cycle; each cell wakes its task if the wake tick has
// been reached and offers it if it beats the best priority so far. The pick
// response is registered once the token leaves the last cell, and no new
// item is taken during the scan. A new item is accepted while a response is
// still held, provided that response is taken in the same cycle.
`default_nettype none

module priority_task_picker_with_wakeup (
    input  wire       i_clk,
    input  wire       i_rst_n,
    ptp_cmd_if.sink   i_cmd,
    ptp_rsp_if.source o_rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                           r_state;
    logic [ptp_pkg::CNT_W-1:0]      r_count;
    logic [ptp_pkg::TICK_W-1:0]     r_tick;
    logic                           r_out_valid;
    logic [ptp_pkg::STAT_W-1:0]     r_status;
    logic [ptp_pkg::IDX_W-1:0]      r_task_id;

    logic                           w_accept;
    logic                           w_full;
    logic                           w_block_ok;
    ptp_pkg::t_token                w_tok [ptp_pkg::MAX_TASKS+1];
    ptp_pkg::t_token                w_last;

    // Input is taken only when idle and the response slot is free.
    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_full     = (r_count >= ptp_pkg::CNT_W'(ptp_pkg::MAX_TASKS));
    assign w_block_ok = ({1'b0, i_cmd.task_index} < r_count);

    // Launch a fresh scan token into the first cell on a pick.
    always_comb begin
        w_tok[0].valid     = w_accept && (i_cmd.cmd == ptp_pkg::CMD_PICK);
        w_tok[0].found     = 1'b0;
        w_tok[0].best_prio = ptp_pkg::PRIO_NEVER;
        w_tok[0].best_id   = '0;
        w_tok[0].pos       = '0;
    end

    // The chain of task cells.
    for (genvar g = 0; g < ptp_pkg::MAX_TASKS; g++) begin : g_cell
        ptp_pkg::t_cell_wr w_wr;

        always_comb begin
            w_wr.create = w_accept && (i_cmd.cmd == ptp_pkg::CMD_CREATE) && !w_full
                          && (r_count[ptp_pkg::IDX_W-1:0] == ptp_pkg::IDX_W'(g));
            w_wr.block  = w_accept && (i_cmd.cmd == ptp_pkg::CMD_BLOCK) && w_block_ok
                          && (i_cmd.task_index == ptp_pkg::IDX_W'(g));
            w_wr.prio   = i_cmd.priority_req;
            w_wr.wake   = i_cmd.wake_at;
        end

        ptp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_tick  (r_tick),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last = w_tok[ptp_pkg::MAX_TASKS];

    // Sequencer, task count and tick counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_tick  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_cmd.cmd)
                            ptp_pkg::CMD_CREATE: begin
                                if (!w_full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            ptp_pkg::CMD_TICK: begin
                                r_tick <= r_tick + 1'b1;
                            end
                            ptp_pkg::CMD_PICK: begin
                                r_state <= ST_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (w_last.valid) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Response valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && (i_cmd.cmd != ptp_pkg::CMD_PICK)) || w_last.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        if (w_last.valid) begin
            r_status  <= w_last.found ? ptp_pkg::STAT_DONE : ptp_pkg::STAT_NONE;
            r_task_id <= w_last.found ? w_last.best_id : '0;
        end else if (w_accept) begin
            r_status  <= ptp_pkg::STAT_DONE;
            r_task_id <= '0;
            if (i_cmd.cmd == ptp_pkg::CMD_CREATE) begin
                if (w_full) begin
                    r_status <= ptp_pkg::STAT_FULL;
                end else begin
                    r_task_id <= r_count[ptp_pkg::IDX_W-1:0];
                end
            end
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_status;
    assign o_rsp.task_id = r_task_id;

endmodule

`default_nettype wire
